FILE: rtl/deb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deb_pkg: shared constants for the deduplicating event buffer
// Command codes and entry field widths.
// ----------------------------------------------------------------------------
package deb_pkg;
  localparam int unsigned DepthDefault = 16;
  localparam int unsigned IdW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned EntryW = IdW + TimeW + DataW;

  localparam logic [3:0] CMD_APPEND = 4'd0;
  localparam logic [3:0] CMD_REMOVE = 4'd1;
  localparam logic [3:0] CMD_SEEK_START = 4'd2;
  localparam logic [3:0] CMD_SEEK_END = 4'd3;
  localparam logic [3:0] CMD_SEEK_INDEX = 4'd4;
  localparam logic [3:0] CMD_SEEK_ID = 4'd5;
  localparam logic [3:0] CMD_STEP_NEXT = 4'd6;
  localparam logic [3:0] CMD_STEP_BACK = 4'd7;
  localparam logic [3:0] CMD_READ_HEAD = 4'd8;
endpackage

FILE: rtl/deb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module deb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/dedup_event_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_event_buffer: ordered event buffer with id deduplication
// Insertion-ordered store of (id, time, data) entries with a cursor.
// ----------------------------------------------------------------------------
// Usage: one command transfer enters on the s_axis group and exactly one
// result transfer leaves on the m_axis group. The block takes one command at
// a time; s_axis_tready is low from acceptance until the result is taken.
// Entries sit in one RAM, read one address a cycle with a registered read.
// A sequencer walks the RAM through a single shared compare/move path:
// the id search issues the address of each entry, then compares the id on
// the registered read data, and removal or eviction compaction copies each
// later entry one place down, reading it and then writing it. A command
// that reads no entry goes straight to the result, a cursor move or a head
// read first reads one entry, and the longest is an evicting append into a
// full buffer followed by a search that misses. The result waits in an
// output register while m_axis_tready is low; nothing else moves meanwhile.
// Reset clears the entry count and the cursor; the RAM contents need no
// clearing since only positions below the count are ever used. No reset
// pass is needed, the block is ready in the cycle after rst falls.
// ----------------------------------------------------------------------------
module dedup_event_buffer #(
  parameter int unsigned DEPTH = deb_pkg::DepthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, low bit up: command[3:0], event_id[19:4], event_time[51:20],
  // event_data[83:52], target_index[91:84], memory_low[92], zero pad to 96.
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata, low bit up: ok[0], entry_valid[1], entry_id[17:2],
  // entry_time[49:18], entry_data[81:50], count[86:82], cursor_valid[87],
  // cursor_index[91:88], zero pad to 96.
  output logic [95:0]  m_axis_tdata
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = deb_pkg::EntryW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EVICT  = 4'd1;  // start compaction from position
  localparam logic [3:0] S_MVRD   = 4'd2;  // read entry i+1
  localparam logic [3:0] S_MVWR   = 4'd3;  // write it at i
  localparam logic [3:0] S_SRCH   = 4'd4;  // issue read of entry i
  localparam logic [3:0] S_SCMP   = 4'd5;  // compare read id
  localparam logic [3:0] S_FOUND  = 4'd6;  // act on search outcome
  localparam logic [3:0] S_RDENT  = 4'd7;  // issue read of result entry
  localparam logic [3:0] S_GETENT = 4'd8;  // capture entry
  localparam logic [3:0] S_DONE   = 4'd9;  // result held

  logic [3:0] state;
  logic [3:0] cmd;
  logic [deb_pkg::IdW-1:0] id;
  logic [deb_pkg::TimeW-1:0] tm;
  logic [deb_pkg::DataW-1:0] dt;
  logic [CW-1:0] count;
  logic [AW-1:0] cpos;
  logic cok;
  logic [CW-1:0] idx;       // walk index
  logic [CW-1:0] gap;       // position being compacted away
  logic found;
  logic [AW-1:0] fpos;
  logic rok, rvalid;
  logic [EW-1:0] rent;
  logic [AW-1:0] rpos;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [deb_pkg::IdW-1:0] rd_id;
  logic [EW-1:0] mv_data;

  assign rd_id = rdata[deb_pkg::IdW-1:0];

  deb_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_DONE);
  assign m_axis_tdata = {4'd0, (cok ? 4'(cpos) : 4'd0), cok,
                         5'(count), rent[EW-1:deb_pkg::IdW+deb_pkg::TimeW],
                         rent[deb_pkg::IdW+deb_pkg::TimeW-1:deb_pkg::IdW],
                         rent[deb_pkg::IdW-1:0], rvalid, rok};

  // Read address and write port are driven by the sequencer state.
  always_comb begin
    raddr = idx[AW-1:0];
    if (state == S_RDENT) raddr = rpos;
    we = 1'b0;
    waddr = gap[AW-1:0];
    wdata = mv_data;
    if (state == S_MVWR) begin
      we = 1'b1;
    end else if (state == S_FOUND && cmd == deb_pkg::CMD_APPEND) begin
      if (found) begin
        we = 1'b1;
        waddr = fpos;
        wdata = {rent[EW-1:deb_pkg::IdW+deb_pkg::TimeW], tm, rent[deb_pkg::IdW-1:0]};
      end else if (count < CW'(DEPTH)) begin
        we = 1'b1;
        waddr = count[AW-1:0];
        wdata = {dt, tm, id};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cpos <= '0;
      cok <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd <= s_axis_tdata[3:0];
            id <= s_axis_tdata[19:4];
            tm <= s_axis_tdata[51:20];
            dt <= s_axis_tdata[83:52];
            rok <= 1'b0;
            rvalid <= 1'b0;
            rent <= '0;
            idx <= '0;
            found <= 1'b0;
            state <= S_DONE;
            case (s_axis_tdata[3:0])
              deb_pkg::CMD_APPEND: begin
                cok <= 1'b0;
                if (s_axis_tdata[92] || count == CW'(DEPTH)) begin
                  if (count != '0) begin
                    gap <= '0;
                    state <= S_EVICT;
                  end
                end else begin
                  state <= S_SRCH;
                end
              end
              deb_pkg::CMD_REMOVE, deb_pkg::CMD_SEEK_ID: begin
                if (s_axis_tdata[3:0] == deb_pkg::CMD_SEEK_ID) cok <= 1'b0;
                state <= S_SRCH;
              end
              deb_pkg::CMD_SEEK_START, deb_pkg::CMD_SEEK_END,
              deb_pkg::CMD_SEEK_INDEX: begin
                cok <= 1'b0;
                if (s_axis_tdata[3:0] == deb_pkg::CMD_SEEK_START && count != '0) begin
                  cpos <= '0; cok <= 1'b1; rpos <= '0; rok <= 1'b1; state <= S_RDENT;
                end else if (s_axis_tdata[3:0] == deb_pkg::CMD_SEEK_END && count != '0) begin
                  cpos <= AW'(count - 1'b1); cok <= 1'b1; rpos <= AW'(count - 1'b1);
                  rok <= 1'b1; state <= S_RDENT;
                end else if (s_axis_tdata[3:0] == deb_pkg::CMD_SEEK_INDEX &&
                             {1'b0, s_axis_tdata[91:84]} < 9'(count)) begin
                  cpos <= AW'(s_axis_tdata[91:84]); cok <= 1'b1;
                  rpos <= AW'(s_axis_tdata[91:84]); rok <= 1'b1; state <= S_RDENT;
                end
              end
              deb_pkg::CMD_STEP_NEXT, deb_pkg::CMD_STEP_BACK: begin
                if (cok && CW'(cpos) < count) begin
                  rpos <= cpos; rok <= 1'b1; state <= S_RDENT;
                  if (s_axis_tdata[3:0] == deb_pkg::CMD_STEP_NEXT) begin
                    if (CW'(cpos) + 1'b1 < count) cpos <= cpos + 1'b1;
                    else cok <= 1'b0;
                  end else begin
                    if (cpos != '0) cpos <= cpos - 1'b1;
                    else cok <= 1'b0;
                  end
                end else begin
                  cok <= 1'b0;
                end
              end
              deb_pkg::CMD_READ_HEAD: begin
                if (count != '0) begin
                  rpos <= '0; rok <= 1'b1; state <= S_RDENT;
                end
              end
              default: ;
            endcase
          end
        end
        S_EVICT: begin
          // Compact from gap: entries gap+1..count-1 move down one place.
          idx <= gap + 1'b1;
          if (gap + 1'b1 < count) state <= S_MVRD;
          else state <= S_MVWR;
        end
        S_MVRD: begin
          state <= S_MVWR;
          if (idx >= count) begin
            // Done moving: shrink and fix the cursor. The removed position
            // is still in fpos; an eviction runs with the cursor cleared.
            count <= count - 1'b1;
            if (cok) begin
              if (cpos == fpos) cok <= 1'b0;
              else if (cpos > fpos) cpos <= cpos - 1'b1;
            end
            idx <= '0;
            if (cmd == deb_pkg::CMD_APPEND) state <= S_SRCH;
            else begin rok <= 1'b1; state <= S_DONE; end
          end
        end
        S_MVWR: begin
          if (idx >= count) begin
            state <= S_MVRD;
          end else begin
            gap <= idx;
            idx <= idx + 1'b1;
            state <= S_MVRD;
          end
        end
        S_SRCH: begin
          if (idx >= count) state <= S_FOUND;
          else state <= S_SCMP;
        end
        S_SCMP: begin
          if (rd_id == id) begin
            found <= 1'b1; fpos <= idx[AW-1:0]; rent <= rdata; state <= S_FOUND;
          end else begin
            idx <= idx + 1'b1; state <= S_SRCH;
          end
        end
        S_FOUND: begin
          state <= S_DONE;
          case (cmd)
            deb_pkg::CMD_APPEND: begin
              rent <= '0;
              if (found) begin
                cpos <= fpos; cok <= 1'b1;
              end else if (count < CW'(DEPTH)) begin
                count <= count + 1'b1; rok <= 1'b1;
              end
            end
            deb_pkg::CMD_REMOVE: begin
              rent <= '0;
              if (found) begin
                gap <= CW'(fpos); state <= S_EVICT;
              end
            end
            default: begin
              if (found) begin
                cpos <= fpos; cok <= 1'b1; rok <= 1'b1; rvalid <= 1'b1;
              end
            end
          endcase
        end
        S_RDENT: state <= S_GETENT;
        S_GETENT: begin
          rent <= rdata; rvalid <= 1'b1; state <= S_DONE;
        end
        S_DONE: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Move data: the entry read in the previous cycle.
  assign mv_data = rdata;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("entry count above depth");
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && cok) |-> (CW'(cpos) < count)) else $error("cursor past end");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && m_axis_tready) |=> state == S_IDLE) else $error("result not retired");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> (count == $past(count) || count == $past(count) + 1'b1 ||
                           count == $past(count) - 1'b1)) else $error("count jumped");
endmodule
